// ===== src/lflp_pkg.sv =====
// ----------------------------------------------------------------------------
// lflp_pkg
// Shared widths, command codes, the node entry type and saturating adders
// for the least-loaded fit placer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lflp_pkg;

    localparam int NODES_DEFAULT = 8;
    localparam int ADDRESSABLE   = 8;
    localparam int NODE_SEL_W    = 3;
    localparam int CMD_W         = 2;
    localparam int COUNT_W       = 4;
    localparam int MEM_W         = 40;
    localparam int COST_W        = 32;
    localparam int LOAD_W        = 48;

    localparam logic [CMD_W-1:0] CMD_LOAD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PREASSIGN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PLACE     = 2'd2;

    typedef struct packed {
        logic [MEM_W-1:0]  capacity;
        logic [MEM_W-1:0]  used;
        logic [LOAD_W-1:0] load;
    } node_entry_t;

    localparam int ENTRY_W = $bits(node_entry_t);

    function automatic logic [MEM_W-1:0] sat_add_mem(
        input logic [MEM_W-1:0] a,
        input logic [MEM_W-1:0] b
    );
        logic [MEM_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[MEM_W] ? {MEM_W{1'b1}} : sum[MEM_W-1:0];
    endfunction

    function automatic logic [LOAD_W-1:0] sat_add_load(
        input logic [LOAD_W-1:0] a,
        input logic [COST_W-1:0] b
    );
        logic [LOAD_W:0] sum;
        sum = {1'b0, a} + {{(LOAD_W-COST_W+1){1'b0}}, b};
        return sum[LOAD_W] ? {LOAD_W{1'b1}} : sum[LOAD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/lflp_node_table.sv =====
// ----------------------------------------------------------------------------
// lflp_node_table
// Node entry memory with one write port and one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lflp_node_table
    import lflp_pkg::*;
#(
    parameter int NODES  = NODES_DEFAULT,
    parameter int ADDR_W = $clog2(NODES)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire node_entry_t       wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output node_entry_t            rd_data
);

    node_entry_t       mem [NODES];
    logic [NODES-1:0]  vld_reg;
    node_entry_t       rd_data_reg;
    logic              rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // an entry never written holds its reset value of zero
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== src/least_loaded_fit_placer_unit.sv =====
// ----------------------------------------------------------------------------
// least_loaded_fit_placer_unit
// Node table with load, preassign and least-loaded first-fit placement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries command, target_node,
//   mem_amount and task_cost. Output channel (out_valid/out_ready)
//   carries chosen_node and fell_back, one transfer per place command only.
//   cfg_write_en/cfg_write_data set node_count; the user is bound to do so
//   only while the block is idle, and the block itself does not enforce it.
//     load      : written in the accepting cycle, next item the cycle after
//     preassign : one read and one write of the node memory
//     place     : one memory read for each of the n active nodes (1 to 8)
//                 in the scan, a final compare, then a read and write of the winner and the result
//   The single read port of the node memory serializes these steps; one item is
//   in work at a time. The result register lets the next item enter while a
//   result waits; a stalled receiver holds a following place at its result.
//   Reset clears all node entries through per-entry valid bits and sets
//   node_count to 1; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module least_loaded_fit_placer_unit
    import lflp_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write_en,
    input  wire logic [COUNT_W-1:0]    cfg_write_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [CMD_W-1:0]      command,
    input  wire logic [NODE_SEL_W-1:0] target_node,
    input  wire logic [MEM_W-1:0]      mem_amount,
    input  wire logic [COST_W-1:0]     task_cost,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [NODE_SEL_W-1:0]      chosen_node,
    output logic                       fell_back
);

    localparam int ADDR_W = $clog2(NODES);
    localparam logic [COUNT_W-1:0] ACTIVE_MAX =
        COUNT_W'((NODES < ADDRESSABLE) ? NODES : ADDRESSABLE);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_LAST   = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_WRITE  = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    active_n;

    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [MEM_W-1:0]      mem_reg, mem_next;
    logic [COST_W-1:0]     cost_reg, cost_next;
    logic [NODE_SEL_W-1:0] target_reg, target_next;
    logic [NODE_SEL_W-1:0] cnt_reg, cnt_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [NODE_SEL_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic                  found_reg, found_next;
    logic [LOAD_W-1:0]     best_load_reg, best_load_next;

    logic                  out_valid_reg, out_valid_next;
    logic [NODE_SEL_W-1:0] chosen_reg, chosen_next;
    logic                  fell_back_reg, fell_back_next;

    logic                  accept;
    logic                  idx_active;
    logic                  tbl_wr_en;
    logic [ADDR_W-1:0]     tbl_wr_addr;
    node_entry_t           tbl_wr_data;
    logic                  tbl_rd_en;
    logic [ADDR_W-1:0]     tbl_rd_addr;
    node_entry_t           tbl_rd_data;

    logic [MEM_W-1:0]      free_mem;
    logic                  fits;
    logic                  better;

    lflp_node_table #(
        .NODES  (NODES),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // active node count clamped to 1..min(NODES, 8)
    always_comb
    begin
        priority if (count_reg == '0)
        begin
            active_n = COUNT_W'(1);
        end
        else if (count_reg > ACTIVE_MAX)
        begin
            active_n = ACTIVE_MAX;
        end
        else
        begin
            active_n = count_reg;
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign idx_active = ({1'b0, target_node} < active_n);

    // scan compare on the entry read in the previous cycle
    assign free_mem = (tbl_rd_data.capacity > tbl_rd_data.used)
                    ? (tbl_rd_data.capacity - tbl_rd_data.used) : '0;
    assign fits     = (free_mem >= mem_reg);
    assign better   = fits && (!found_reg || (tbl_rd_data.load < best_load_reg));

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        mem_next       = mem_reg;
        cost_next      = cost_reg;
        target_next    = target_reg;
        cnt_next       = cnt_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        best_load_next = best_load_reg;
        out_valid_next = out_valid_reg;
        chosen_next    = chosen_reg;
        fell_back_next = fell_back_reg;

        tbl_wr_en   = 1'b0;
        tbl_wr_addr = ADDR_W'(target_reg);
        tbl_wr_data = tbl_rd_data;
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = ADDR_W'(cnt_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmp_vld_reg && better)
        begin
            found_next     = 1'b1;
            target_next    = cmp_idx_reg;
            best_load_next = tbl_rd_data.load;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = command;
                    mem_next  = mem_amount;
                    cost_next = task_cost;
                    priority if (command == CMD_LOAD)
                    begin
                        tbl_wr_en            = idx_active;
                        tbl_wr_addr          = ADDR_W'(target_node);
                        tbl_wr_data.capacity = mem_amount;
                        tbl_wr_data.used     = '0;
                        tbl_wr_data.load     = '0;
                    end
                    else if (command == CMD_PREASSIGN)
                    begin
                        target_next = target_node;
                        if (idx_active)
                        begin
                            state_next = S_READ;
                        end
                    end
                    else if (command == CMD_PLACE)
                    begin
                        target_next = '0;
                        cnt_next    = '0;
                        found_next  = 1'b0;
                        state_next  = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SCAN:
            begin
                tbl_rd_en    = 1'b1;
                cmp_vld_next = 1'b1;
                cmp_idx_next = cnt_reg;
                cnt_next     = cnt_reg + 1'b1;
                if ({1'b0, cnt_reg} == (active_n - 1'b1))
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                // final compare lands in this cycle
                state_next = S_READ;
            end
            S_READ:
            begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = ADDR_W'(target_reg);
                state_next  = S_WRITE;
            end
            S_WRITE:
            begin
                tbl_wr_en        = 1'b1;
                tbl_wr_data.used = sat_add_mem(tbl_rd_data.used, mem_reg);
                tbl_wr_data.load = sat_add_load(tbl_rd_data.load, cost_reg);
                state_next       = (cmd_reg == CMD_PLACE) ? S_RESULT : S_IDLE;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    chosen_next    = target_reg;
                    fell_back_next = !found_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= COUNT_W'(1);
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                count_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        mem_reg       <= mem_next;
        cost_reg      <= cost_next;
        target_reg    <= target_next;
        cnt_reg       <= cnt_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_load_reg <= best_load_next;
        chosen_reg    <= chosen_next;
        fell_back_reg <= fell_back_next;
    end

    assign out_valid   = out_valid_reg;
    assign chosen_node = chosen_reg;
    assign fell_back   = fell_back_reg;

endmodule

`default_nettype wire

// ===== sim/lflp_placement_checker.sv =====
// ----------------------------------------------------------------------------
// lflp_placement_checker
// Watches the command and result channels of the least-loaded fit placer,
// keeps its own copy of the node table and the node count, predicts the
// node chosen for every place command and compares each result transfer
// against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lflp_placement_checker
    import lflp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write_en,
    input  wire logic [COUNT_W-1:0]    cfg_write_data,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [CMD_W-1:0]      command,
    input  wire logic [NODE_SEL_W-1:0] target_node,
    input  wire logic [MEM_W-1:0]      mem_amount,
    input  wire logic [COST_W-1:0]     task_cost,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [NODE_SEL_W-1:0] chosen_node,
    input  wire logic                  fell_back,
    output int                         error_count,
    output int                         results_due,
    output int                         placements_seen,
    output int                         fallbacks_seen
);

    typedef struct packed {
        logic [NODE_SEL_W-1:0] node;
        logic                  no_fit;
    } placement_t;

    logic [MEM_W-1:0]   capacity_q [NODES_DEFAULT];
    logic [MEM_W-1:0]   used_q     [NODES_DEFAULT];
    logic [LOAD_W-1:0]  load_q     [NODES_DEFAULT];
    logic [COUNT_W-1:0] node_count_q;
    placement_t         placements_due [$];

    initial
    begin
        error_count     = 0;
        results_due     = 0;
        placements_seen = 0;
        fallbacks_seen  = 0;
    end

    function automatic int unsigned active_nodes();
        if (node_count_q == 0)
            return 1;
        if (node_count_q > ADDRESSABLE)
            return ADDRESSABLE;
        return 32'(node_count_q);
    endfunction

    function automatic logic [MEM_W-1:0] mem_plus(
        input logic [MEM_W-1:0] a,
        input logic [MEM_W-1:0] b
    );
        // ~a is the headroom left below the all-ones ceiling
        if (b > ~a)
            return {MEM_W{1'b1}};
        return a + b;
    endfunction

    function automatic logic [LOAD_W-1:0] load_plus(
        input logic [LOAD_W-1:0] a,
        input logic [COST_W-1:0] b
    );
        logic [LOAD_W-1:0] wide_b;
        wide_b = {{(LOAD_W-COST_W){1'b0}}, b};
        if (wide_b > ~a)
            return {LOAD_W{1'b1}};
        return a + wide_b;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic charge_node(
        input int unsigned       slot,
        input logic [MEM_W-1:0]  need,
        input logic [COST_W-1:0] cost
    );
        used_q[slot] = mem_plus(used_q[slot], need);
        load_q[slot] = load_plus(load_q[slot], cost);
    endtask

    task automatic apply_command(
        input logic [CMD_W-1:0]      cmd,
        input logic [NODE_SEL_W-1:0] target,
        input logic [MEM_W-1:0]      need,
        input logic [COST_W-1:0]     cost
    );
        int unsigned      limit;
        int unsigned      best;
        logic             found;
        logic [MEM_W-1:0] room;
        placement_t       pick;
        limit = active_nodes();
        best  = 0;
        found = 1'b0;
        case (cmd)
            CMD_LOAD:
            begin
                if (target < limit)
                begin
                    capacity_q[target] = need;
                    used_q[target]     = '0;
                    load_q[target]     = '0;
                end
            end
            CMD_PREASSIGN:
            begin
                if (target < limit)
                    charge_node(32'(target), need, cost);
            end
            CMD_PLACE:
            begin
                for (int i = 0; i < limit; i++)
                begin
                    room = (capacity_q[i] > used_q[i]) ? capacity_q[i] - used_q[i] : '0;
                    // strict less keeps the lowest index among equal loads
                    if (room >= need && (!found || load_q[i] < load_q[best]))
                    begin
                        found = 1'b1;
                        best  = i;
                    end
                end
                charge_node(best, need, cost);
                pick.node   = best[NODE_SEL_W-1:0];
                pick.no_fit = ~found;
                placements_due.insert(placements_due.size(), pick);
                if (!found)
                    fallbacks_seen++;
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : observe
        placement_t due;
        if (!rst_n)
        begin
            for (int i = 0; i < NODES_DEFAULT; i++)
            begin
                capacity_q[i] = '0;
                used_q[i]     = '0;
                load_q[i]     = '0;
            end
            node_count_q = COUNT_W'(1);
            placements_due.delete();
        end
        else
        begin
            if (cfg_write_en)
                node_count_q = cfg_write_data;
            // a result leaving now always belongs to an earlier command
            if (out_valid && out_ready)
            begin
                placements_seen++;
                if (placements_due.size() == 0)
                    report_mismatch("result transfer with no placement pending");
                else
                begin
                    due = placements_due.pop_front();
                    if (chosen_node !== due.node)
                        report_mismatch($sformatf("chosen_node %0d, predicted %0d",
                                                  chosen_node, due.node));
                    if (fell_back !== due.no_fit)
                        report_mismatch($sformatf("fell_back %0b, predicted %0b",
                                                  fell_back, due.no_fit));
                end
            end
            if (in_valid && in_ready)
                apply_command(command, target_node, mem_amount, task_cost);
        end
        results_due = placements_due.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for least_loaded_fit_placer_unit. A directed opening
// covers empty tables, ties, full and over-full nodes, saturation, inactive
// targets and the unused command; then random phases each set a node count,
// load the nodes and run place-heavy command streams with random stalls on
// both channels. Prediction and comparison live in lflp_placement_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import lflp_pkg::*;
;

    localparam int unsigned TARGET_ITEMS   = 1400;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned HOLD_CYCLES    = 160;
    localparam int unsigned SETTLE_CYCLES  = 16;

    localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [MEM_W-1:0]  MEM_ALL    = {MEM_W{1'b1}};
    localparam logic [COST_W-1:0] COST_ALL   = {COST_W{1'b1}};

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_write_en   = 1'b0;
    logic [COUNT_W-1:0]    cfg_write_data = '0;
    logic                  in_valid       = 1'b0;
    logic [CMD_W-1:0]      command        = CMD_LOAD;
    logic [NODE_SEL_W-1:0] target_node    = '0;
    logic [MEM_W-1:0]      mem_amount     = '0;
    logic [COST_W-1:0]     task_cost      = '0;
    logic                  out_ready      = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic [NODE_SEL_W-1:0] chosen_node;
    logic                  fell_back;

    int error_count;
    int results_due;
    int placements_seen;
    int fallbacks_seen;

    int unsigned active_now      = 1;
    int unsigned effective_items = 0;
    int unsigned sent_items      = 0;
    int unsigned count_writes    = 0;
    int unsigned tx_quiet        = 0;
    int unsigned rx_quiet        = 0;
    bit          rx_hold_req     = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    least_loaded_fit_placer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .target_node    (target_node),
        .mem_amount     (mem_amount),
        .task_cost      (task_cost),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .chosen_node    (chosen_node),
        .fell_back      (fell_back)
    );

    lflp_placement_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .target_node     (target_node),
        .mem_amount      (mem_amount),
        .task_cost       (task_cost),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .chosen_node     (chosen_node),
        .fell_back       (fell_back),
        .error_count     (error_count),
        .results_due     (results_due),
        .placements_seen (placements_seen),
        .fallbacks_seen  (fallbacks_seen)
    );

    // idle cycles for one transfer, with occasional stretches of none
    task automatic draw_wait(inout int unsigned quiet_left, output int unsigned cycles);
        if (quiet_left > 0)
        begin
            quiet_left--;
            cycles = 0;
        end
        else
        begin
            if ($urandom_range(0, 11) == 0)
                quiet_left = $urandom_range(10, 40);
            cycles = $urandom_range(0, 7);
        end
    endtask

    function automatic logic [MEM_W-1:0] rand_mem();
        logic [63:0] word;
        word = {$urandom, $urandom};
        return word[MEM_W-1:0];
    endfunction

    function automatic logic [MEM_W-1:0] pick_capacity(input int unsigned shift);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return MEM_ALL;
        return rand_mem() >> shift;
    endfunction

    // task needs mostly sit one to three binary orders below the phase's capacities
    function automatic logic [MEM_W-1:0] pick_need(input int unsigned shift);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return MEM_ALL;
        if (r == 2)
            return rand_mem();
        return rand_mem() >> (shift + $urandom_range(1, 3));
    endfunction

    function automatic logic [COST_W-1:0] pick_cost();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return COST_ALL;
        if (r < 5)
            return $urandom_range(0, 3);
        return $urandom >> $urandom_range(0, 31);
    endfunction

    task automatic send_item(
        input logic [CMD_W-1:0]      cmd,
        input logic [NODE_SEL_W-1:0] target,
        input logic [MEM_W-1:0]      need,
        input logic [COST_W-1:0]     cost
    );
        int unsigned gap;
        draw_wait(tx_quiet, gap);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        target_node <= target;
        mem_amount  <= need;
        task_cost   <= cost;
        do @(posedge clk); while (!in_ready);
        sent_items++;
        if (cmd == CMD_PLACE || (cmd != CMD_UNUSED && target < active_now))
            effective_items++;
    endtask

    // node count changes only once the block has drained
    task automatic set_node_count(input logic [COUNT_W-1:0] setting);
        @(negedge clk);
        in_valid <= 1'b0;
        wait (results_due == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= setting;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        if (setting == 0)
            active_now = 1;
        else if (setting > ADDRESSABLE)
            active_now = ADDRESSABLE;
        else
            active_now = 32'(setting);
        count_writes++;
    endtask

    always
    begin : result_sink
        int unsigned wait_cycles;
        if (rx_hold_req)
        begin
            rx_hold_req = 1'b0;
            @(negedge clk);
            out_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clk);
        end
        draw_wait(rx_quiet, wait_cycles);
        @(negedge clk);
        if (wait_cycles > 0)
        begin
            out_ready <= 1'b0;
            repeat (wait_cycles) @(negedge clk);
        end
        out_ready <= 1'b1;
        do @(posedge clk); while (!(out_valid && out_ready));
    end

    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, results_due);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned        phase;
        int unsigned        shift;
        int unsigned        burst;
        int unsigned        r;
        int unsigned        pick_idx;
        logic [COUNT_W-1:0] setting;
        phase = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fresh table, one node of zero capacity
        send_item(CMD_PLACE, 3'd0, '0, '0);
        send_item(CMD_PLACE, 3'd7, 40'd1, COST_ALL);
        send_item(CMD_UNUSED, 3'd5, MEM_ALL, COST_ALL);
        send_item(CMD_LOAD, 3'd3, 40'd500, 32'd9);
        send_item(CMD_PREASSIGN, 3'd1, 40'd10, 32'd10);

        set_node_count(4'd8);
        for (int n = 0; n < 8; n++)
            send_item(CMD_LOAD, NODE_SEL_W'(n),
                      (n == 0) ? '0 : ((n == 7) ? MEM_ALL : 40'd100), '0);
        // equal loads: lowest fitting index wins
        send_item(CMD_PLACE, 3'd0, 40'd100, 32'd7);
        send_item(CMD_PLACE, 3'd0, 40'd100, 32'd7);
        send_item(CMD_PLACE, 3'd0, 40'd101, 32'd3);
        // used memory saturates, then node 5 goes over-full
        send_item(CMD_PREASSIGN, 3'd7, MEM_ALL, COST_ALL);
        send_item(CMD_PREASSIGN, 3'd7, MEM_ALL, COST_ALL);
        send_item(CMD_PREASSIGN, 3'd5, 40'd300, '0);
        send_item(CMD_PLACE, 3'd0, 40'd1, '0);
        send_item(CMD_PLACE, 3'd0, 40'd200, 32'd2);
        send_item(CMD_PLACE, 3'd0, '0, 32'd5);

        // a zero count still leaves node 0 active
        set_node_count(4'd0);
        send_item(CMD_PLACE, 3'd0, '0, 32'd1);
        send_item(CMD_LOAD, 3'd0, MEM_ALL, '0);
        send_item(CMD_PLACE, 3'd0, MEM_ALL, COST_ALL);
        set_node_count(4'd15);
        send_item(CMD_PLACE, 3'd0, '0, '0);

        while (sent_items < TARGET_ITEMS)
        begin
            case (phase % 6)
                0:       setting = 4'd8;
                1:       setting = 4'd1;
                2:       setting = COUNT_W'($urandom_range(2, 7));
                3:       setting = 4'd0;
                4:       setting = 4'd15;
                default: setting = COUNT_W'($urandom_range(0, 15));
            endcase
            set_node_count(setting);
            shift = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 36);
            for (int n = 0; n < active_now; n++)
                send_item(CMD_LOAD, NODE_SEL_W'(n), pick_capacity(shift), pick_cost());
            // receiver stops for a while so places back up into the input
            if (phase == 2)
                rx_hold_req = 1'b1;
            burst = $urandom_range(20, 60);
            repeat (burst)
            begin
                r = $urandom_range(0, 99);
                if ($urandom_range(0, 4) == 0)
                    pick_idx = $urandom_range(0, 7);
                else
                    pick_idx = $urandom_range(0, active_now - 1);
                if (r < 70)
                    send_item(CMD_PLACE, NODE_SEL_W'($urandom_range(0, 7)),
                              pick_need(shift), pick_cost());
                else if (r < 82)
                    send_item(CMD_PREASSIGN, NODE_SEL_W'(pick_idx),
                              pick_need(shift), pick_cost());
                else if (r < 88)
                    send_item(CMD_LOAD, NODE_SEL_W'(pick_idx),
                              pick_capacity(shift), pick_cost());
                else if (r < 93)
                    send_item(CMD_UNUSED, NODE_SEL_W'($urandom_range(0, 7)),
                              rand_mem(), $urandom);
                else
                    send_item(CMD_PLACE, NODE_SEL_W'($urandom_range(0, 7)),
                              rand_mem(), $urandom);
            end
            phase++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (results_due == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("summary: %0d commands sent, %0d with effect, %0d node count writes",
                 sent_items, effective_items, count_writes);
        $display("summary: %0d placements compared, %0d fell back to node 0,",
                 placements_seen, fallbacks_seen);
        $display("summary: one %0d-cycle result stall", HOLD_CYCLES);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
